// ===== rtl/sacf_pkg.sv =====
package sacf_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int CORDIC_ITERS   = 22;
    localparam int PRESCALE       = 24;
    // Headroom above the scaled magnitude for CORDIC gain and vector length.
    localparam int GUARD_BITS     = 3;
    localparam int GAIN_W         = 31;
    localparam logic [GAIN_W-1:0] GAIN_Q30 = 31'd1768195363;
    localparam int GAIN_SHIFT     = 30 - PRESCALE;

    localparam int ACC_W   = 24;
    localparam int ANG_W   = 15;
    localparam int AZ_W    = 16;
    localparam int CD_W    = ACC_W - 8;

    localparam logic [ANG_W-1:0] QUARTER_TURN = 15'd9000;
    localparam logic [ANG_W-1:0] HALF_TURN    = 15'd18000;

    localparam logic signed [ACC_W-1:0] ATAN_TAB [CORDIC_ITERS] = '{
        24'sd1152000, 24'sd680065, 24'sd359328, 24'sd182400, 24'sd91554,
        24'sd45822, 24'sd22916, 24'sd11459, 24'sd5730, 24'sd2865,
        24'sd1432, 24'sd716, 24'sd358, 24'sd179, 24'sd90, 24'sd45,
        24'sd22, 24'sd11, 24'sd6, 24'sd3, 24'sd1, 24'sd1
    };

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_AZ_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AZ_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POL_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POL_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REMOVE  = 3'd4;

    localparam logic signed [AZ_W-1:0] AZ_MIN_RST = -16'sd18000;
    localparam logic signed [AZ_W-1:0] AZ_MAX_RST = 16'sd18000;

endpackage

// ===== rtl/spherical_angle_crop_filter_core.sv =====
// Channel   Signals                                        Direction
// input     i_in_valid, o_in_stall, i_coord_x/y/z          point beat in
// output    o_out_valid, i_out_stall, o_kept_x/y/z         kept point beat out
// config    i_cfg_valid, o_cfg_ready, i_cfg_index/data     register write
//
// One point is accepted per cycle unless the output is stalled. The path
// is an input register, two chained 22-iteration CORDIC pipelines with one
// finishing stage each, and the output register. Dropped points leave no
// beat on the output. Reset is synchronous, active low; it clears the valid
// bits and loads the window registers with their defaults.
// A stalled output beat freezes the whole pipeline, so nothing is lost.
module spherical_angle_crop_filter_core #(
    parameter int COORD_BITS = sacf_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [COORD_BITS-1:0]      i_coord_x,
    input  logic signed [COORD_BITS-1:0]      i_coord_y,
    input  logic signed [COORD_BITS-1:0]      i_coord_z,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [COORD_BITS-1:0]      o_kept_x,
    output logic signed [COORD_BITS-1:0]      o_kept_y,
    output logic signed [COORD_BITS-1:0]      o_kept_z,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sacf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sacf_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int CB     = COORD_BITS;
    localparam int W      = CB + sacf_pkg::PRESCALE + sacf_pkg::GUARD_BITS;
    localparam int PROD_W = CB + sacf_pkg::GAIN_W;
    localparam int SBA_W  = 3 * CB + W;
    localparam int SBB_W  = 3 * CB + sacf_pkg::AZ_W;
    localparam int ANG_W  = sacf_pkg::ANG_W;
    localparam int AZ_W   = sacf_pkg::AZ_W;

    logic en;

    logic signed [AZ_W-1:0]  r_az_min;
    logic signed [AZ_W-1:0]  r_az_max;
    logic [ANG_W-1:0]        r_pol_min;
    logic [ANG_W-1:0]        r_pol_max;
    logic                    r_remove;

    logic [CB-1:0]           mag_z_in;
    logic                    r_s0_valid;
    logic signed [CB-1:0]    r_s0_x;
    logic signed [CB-1:0]    r_s0_y;
    logic signed [CB-1:0]    r_s0_z;
    logic [PROD_W-1:0]       r_s0_prod;

    logic [CB-1:0]           mag_x;
    logic [CB-1:0]           mag_y;
    logic [PROD_W-1:0]       zk_sum;
    logic signed [W-1:0]     zk;
    logic signed [W-1:0]     ax_in;
    logic signed [W-1:0]     ay_in;
    logic                    a_valid_in;

    logic                    a_valid;
    logic [ANG_W-1:0]        a_angle;
    logic signed [W-1:0]     a_mag;
    logic [SBA_W-1:0]        a_sb;
    logic signed [CB-1:0]    a_x;
    logic signed [CB-1:0]    a_y;
    logic signed [CB-1:0]    a_z;
    logic signed [W-1:0]     a_zk;
    logic [ANG_W-1:0]        a_half;
    logic signed [AZ_W-1:0]  phi;

    logic                    b_valid;
    logic [ANG_W-1:0]        b_angle;
    logic signed [W-1:0]     b_mag;
    logic [SBB_W-1:0]        b_sb;
    logic signed [CB-1:0]    b_x;
    logic signed [CB-1:0]    b_y;
    logic signed [CB-1:0]    b_z;
    logic signed [AZ_W-1:0]  b_phi;
    logic [ANG_W-1:0]        theta;
    logic                    pass;

    logic                    r_out_valid;
    logic signed [CB-1:0]    r_out_x;
    logic signed [CB-1:0]    r_out_y;
    logic signed [CB-1:0]    r_out_z;

    assign en          = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_az_min  <= sacf_pkg::AZ_MIN_RST;
            r_az_max  <= sacf_pkg::AZ_MAX_RST;
            r_pol_min <= '0;
            r_pol_max <= sacf_pkg::HALF_TURN;
            r_remove  <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sacf_pkg::CFG_AZ_MIN:  r_az_min  <= i_cfg_data;
                sacf_pkg::CFG_AZ_MAX:  r_az_max  <= i_cfg_data;
                sacf_pkg::CFG_POL_MIN: r_pol_min <= i_cfg_data[ANG_W-1:0];
                sacf_pkg::CFG_POL_MAX: r_pol_max <= i_cfg_data[ANG_W-1:0];
                sacf_pkg::CFG_REMOVE:  r_remove  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input stage: capture the point and start the gain multiply on |z|.
    assign mag_z_in = i_coord_z[CB-1] ? -i_coord_z : i_coord_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (en) begin
            r_s0_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_x    <= i_coord_x;
            r_s0_y    <= i_coord_y;
            r_s0_z    <= i_coord_z;
            r_s0_prod <= PROD_W'(mag_z_in) * PROD_W'(sacf_pkg::GAIN_Q30);
        end
    end

    assign mag_x  = r_s0_x[CB-1] ? -r_s0_x : r_s0_x;
    assign mag_y  = r_s0_y[CB-1] ? -r_s0_y : r_s0_y;
    assign zk_sum = r_s0_prod + PROD_W'(32);
    assign zk     = W'(zk_sum >> sacf_pkg::GAIN_SHIFT);
    assign ax_in  = {{sacf_pkg::GUARD_BITS{1'b0}}, mag_x, {sacf_pkg::PRESCALE{1'b0}}};
    assign ay_in  = {{sacf_pkg::GUARD_BITS{1'b0}}, mag_y, {sacf_pkg::PRESCALE{1'b0}}};
    // A point at zero planar radius never enters the angle pipelines.
    assign a_valid_in = r_s0_valid && ((r_s0_x != '0) || (r_s0_y != '0));

    sacf_cordic #(
        .W    (W),
        .SB_W (SBA_W)
    ) u_azimuth (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (a_valid_in),
        .i_x     (ax_in),
        .i_y     (ay_in),
        .i_sb    ({r_s0_x, r_s0_y, r_s0_z, zk}),
        .o_valid (a_valid),
        .o_angle (a_angle),
        .o_mag   (a_mag),
        .o_sb    (a_sb)
    );

    assign {a_x, a_y, a_z, a_zk} = a_sb;
    assign a_half = a_x[CB-1] ? (sacf_pkg::HALF_TURN - a_angle) : a_angle;
    assign phi    = a_y[CB-1] ? -$signed({1'b0, a_half}) : $signed({1'b0, a_half});

    sacf_cordic #(
        .W    (W),
        .SB_W (SBB_W)
    ) u_polar (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (a_valid),
        .i_x     (a_zk),
        .i_y     (a_mag),
        .i_sb    ({a_x, a_y, a_z, phi}),
        .o_valid (b_valid),
        .o_angle (b_angle),
        .o_mag   (b_mag),
        .o_sb    (b_sb)
    );

    assign {b_x, b_y, b_z, b_phi} = b_sb;
    assign theta = b_z[CB-1] ? (sacf_pkg::HALF_TURN - b_angle) : b_angle;

    always_comb begin
        if (r_remove) begin
            pass = (b_phi < r_az_min) || (r_az_max < b_phi) ||
                   (theta < r_pol_min) || (r_pol_max < theta);
        end else begin
            pass = (r_az_min < b_phi) && (b_phi < r_az_max) &&
                   (r_pol_min < theta) && (theta < r_pol_max);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= b_valid && pass && (b_mag == b_mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_x <= b_x;
            r_out_y <= b_y;
            r_out_z <= b_z;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kept_x    = r_out_x;
    assign o_kept_y    = r_out_y;
    assign o_kept_z    = r_out_z;

endmodule

// ===== rtl/sacf_cordic_stage.sv =====
module sacf_cordic_stage #(
    parameter int W    = 43,
    parameter int SB_W = 8,
    parameter int IDX  = 0
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic signed [W-1:0]             i_x,
    input  logic signed [W-1:0]             i_y,
    input  logic signed [sacf_pkg::ACC_W-1:0] i_acc,
    input  logic [SB_W-1:0]                 i_sb,
    output logic                            o_valid,
    output logic signed [W-1:0]             o_x,
    output logic signed [W-1:0]             o_y,
    output logic signed [sacf_pkg::ACC_W-1:0] o_acc,
    output logic [SB_W-1:0]                 o_sb
);

    logic signed [W-1:0] xs;
    logic signed [W-1:0] ys;
    logic signed [W-1:0] n_x;
    logic signed [W-1:0] n_y;
    logic signed [sacf_pkg::ACC_W-1:0] n_acc;
    logic r_valid;
    logic signed [W-1:0] r_x;
    logic signed [W-1:0] r_y;
    logic signed [sacf_pkg::ACC_W-1:0] r_acc;
    logic [SB_W-1:0] r_sb;

    assign xs = i_x >>> IDX;
    assign ys = i_y >>> IDX;

    always_comb begin
        if (!i_y[W-1]) begin
            n_x   = i_x + ys;
            n_y   = i_y - xs;
            n_acc = i_acc + sacf_pkg::ATAN_TAB[IDX];
        end else begin
            n_x   = i_x - ys;
            n_y   = i_y + xs;
            n_acc = i_acc - sacf_pkg::ATAN_TAB[IDX];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_acc <= n_acc;
            r_sb  <= i_sb;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_acc   = r_acc;
    assign o_sb    = r_sb;

endmodule

// ===== rtl/sacf_cordic.sv =====
module sacf_cordic #(
    parameter int W    = 43,
    parameter int SB_W = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic signed [W-1:0]               i_x,
    input  logic signed [W-1:0]               i_y,
    input  logic [SB_W-1:0]                   i_sb,
    output logic                              o_valid,
    output logic [sacf_pkg::ANG_W-1:0]        o_angle,
    output logic signed [W-1:0]               o_mag,
    output logic [SB_W-1:0]                   o_sb
);

    localparam int N = sacf_pkg::CORDIC_ITERS;

    logic                              v   [0:N];
    logic signed [W-1:0]               xa  [0:N];
    logic signed [W-1:0]               ya  [0:N];
    logic signed [sacf_pkg::ACC_W-1:0] acc [0:N];
    logic [SB_W-1:0]                   sb  [0:N];

    logic [sacf_pkg::ACC_W-1:0] acc_pos;
    logic [sacf_pkg::ACC_W-1:0] acc_rnd;
    logic [sacf_pkg::CD_W-1:0]  cd;
    logic [sacf_pkg::ANG_W-1:0] n_angle;
    logic                       r_valid;
    logic [sacf_pkg::ANG_W-1:0] r_angle;
    logic signed [W-1:0]        r_mag;
    logic [SB_W-1:0]            r_sb;

    assign v[0]   = i_valid;
    assign xa[0]  = i_x;
    assign ya[0]  = i_y;
    assign acc[0] = '0;
    assign sb[0]  = i_sb;

    for (genvar g = 0; g < N; g++) begin : g_iter
        sacf_cordic_stage #(
            .W    (W),
            .SB_W (SB_W),
            .IDX  (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (v[g]),
            .i_x     (xa[g]),
            .i_y     (ya[g]),
            .i_acc   (acc[g]),
            .i_sb    (sb[g]),
            .o_valid (v[g+1]),
            .o_x     (xa[g+1]),
            .o_y     (ya[g+1]),
            .o_acc   (acc[g+1]),
            .o_sb    (sb[g+1])
        );
    end

    // Accumulator is in 1/256 centidegree; clamp, round, clamp to a quarter turn.
    assign acc_pos = acc[N][sacf_pkg::ACC_W-1] ? '0 : acc[N];
    assign acc_rnd = acc_pos + sacf_pkg::ACC_W'(128);
    assign cd      = acc_rnd[sacf_pkg::ACC_W-1:8];
    assign n_angle = (cd > sacf_pkg::CD_W'(sacf_pkg::QUARTER_TURN))
                   ? sacf_pkg::QUARTER_TURN : cd[sacf_pkg::ANG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= v[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle <= n_angle;
            r_mag   <= xa[N];
            r_sb    <= sb[N];
        end
    end

    assign o_valid = r_valid;
    assign o_angle = r_angle;
    assign o_mag   = r_mag;
    assign o_sb    = r_sb;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int CB = 16;
    localparam int LATENCY = 48;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int NUM_RANDOM = 1950;
    localparam logic [sacf_pkg::CFG_IDX_W-1:0] CFG_BOGUS = 3'd7;

    typedef struct packed {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic signed [CB-1:0] z;
    } point_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic signed [CB-1:0] i_coord_x = '0, i_coord_y = '0, i_coord_z = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [CB-1:0] o_kept_x, o_kept_y, o_kept_z;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [sacf_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [sacf_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    spherical_angle_crop_filter_core #(.COORD_BITS(CB)) dut (.*);

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Predictor state: window registers.
    int az_lo, az_hi, pol_lo, pol_hi;
    bit drop_inside;

    point_t pending_points[$];
    point_t kept_points[$];
    int mismatches = 0;
    int quiet_cycles = 0;
    bit calm = 1'b0;
    bit hold_sender = 1'b0;
    bit stim_done = 1'b0;
    // Set at the rising edge that accepts an input beat.
    bit in_taken = 1'b0;

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic int quadrant_angle(longint xv, longint yv, output longint mag);
        longint acc;
        longint xs, ys;
        acc = 0;
        for (int i = 0; i < sacf_pkg::CORDIC_ITERS; i++) begin
            xs = fshift(xv, i);
            ys = fshift(yv, i);
            if (yv >= 0) begin
                xv = xv + ys;
                yv = yv - xs;
                acc = acc + longint'(sacf_pkg::ATAN_TAB[i]);
            end else begin
                xv = xv - ys;
                yv = yv + xs;
                acc = acc - longint'(sacf_pkg::ATAN_TAB[i]);
            end
        end
        mag = xv;
        if (acc < 0) acc = 0;
        acc = (acc + 128) >>> 8;
        if (acc > 9000) acc = 9000;
        return int'(acc);
    endfunction

    function automatic bit point_passes(point_t p);
        longint x, y, z, ax, ay, az, rho, scratch, zk;
        int a, phi, t;
        x = p.x; y = p.y; z = p.z;
        if (x == 0 && y == 0) return 1'b0;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        az = (z < 0) ? -z : z;
        a = quadrant_angle(ax <<< sacf_pkg::PRESCALE, ay <<< sacf_pkg::PRESCALE, rho);
        if (x < 0) a = 18000 - a;
        phi = (y < 0) ? -a : a;
        zk = (az * longint'(sacf_pkg::GAIN_Q30) + 32) >>> sacf_pkg::GAIN_SHIFT;
        t = quadrant_angle(zk, rho, scratch);
        if (z < 0) t = 18000 - t;
        if (drop_inside)
            return (phi < az_lo) || (az_hi < phi) || (t < pol_lo) || (pol_hi < t);
        return (az_lo < phi) && (phi < az_hi) && (pol_lo < t) && (t < pol_hi);
    endfunction

    // Driver: inputs change on the falling edge.
    always @(negedge i_clk) begin
        if (in_taken) begin
            pending_points.pop_front();
        end
        if (i_in_valid && !in_taken) begin
            // Hold the stalled beat.
        end else if (pending_points.size() > 0 && !hold_sender
                     && (calm || $urandom_range(99) >= 35)) begin
            i_in_valid <= 1'b1;
            i_coord_x <= pending_points[0].x;
            i_coord_y <= pending_points[0].y;
            i_coord_z <= pending_points[0].z;
        end else begin
            i_in_valid <= 1'b0;
        end
        in_taken = 1'b0;
        i_out_stall <= !calm && ($urandom_range(99) < 35);
    end

    // The pop above runs on the edge after acceptance, so prediction happens
    // at the accepting rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            in_taken = 1'b1;
            if (point_passes(pending_points[0])) kept_points.push_back(pending_points[0]);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (kept_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat exp none got %0d %0d %0d",
                             o_kept_x, o_kept_y, o_kept_z);
            end else begin
                if (o_kept_x !== kept_points[0].x || o_kept_y !== kept_points[0].y
                    || o_kept_z !== kept_points[0].z) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %0d %0d %0d got %0d %0d %0d",
                                 kept_points[0].x, kept_points[0].y, kept_points[0].z,
                                 o_kept_x, o_kept_y, o_kept_z);
                end
                kept_points.pop_front();
            end
        end
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready) || pending_points.size() == 0
               && kept_points.size() == 0)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [sacf_pkg::CFG_IDX_W-1:0] idx,
                             logic [sacf_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        unique case (idx)
            sacf_pkg::CFG_AZ_MIN: az_lo = int'($signed(val));
            sacf_pkg::CFG_AZ_MAX: az_hi = int'($signed(val));
            sacf_pkg::CFG_POL_MIN: pol_lo = int'(val[14:0]);
            sacf_pkg::CFG_POL_MAX: pol_hi = int'(val[14:0]);
            sacf_pkg::CFG_REMOVE: drop_inside = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_points.size() > 0 || kept_points.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic set_window(int alo, int ahi, int plo, int phi_, bit rem);
        write_reg(sacf_pkg::CFG_AZ_MIN, 16'(alo));
        write_reg(sacf_pkg::CFG_AZ_MAX, 16'(ahi));
        write_reg(sacf_pkg::CFG_POL_MIN, 16'(plo));
        write_reg(sacf_pkg::CFG_POL_MAX, 16'(phi_));
        write_reg(sacf_pkg::CFG_REMOVE, 16'(rem));
    endtask

    function automatic point_t rand_point();
        point_t p;
        int r;
        r = $urandom_range(9);
        p.x = CB'($urandom); p.y = CB'($urandom); p.z = CB'($urandom);
        if (r == 0) begin
            p.x = CB'(int'($urandom_range(3)) - 1);
            p.y = CB'(int'($urandom_range(3)) - 1);
        end else if (r == 1) begin
            p.y = '0;
        end else if (r == 2) begin
            p.x = CB'(int'($urandom_range(255)) - 128);
            p.y = CB'(int'($urandom_range(255)) - 128);
            p.z = CB'(int'($urandom_range(255)) - 128);
        end
        return p;
    endfunction

    task automatic push_random(int n);
        repeat (n) pending_points.push_back(rand_point());
    endtask

    initial begin
        az_lo = -18000; az_hi = 18000; pol_lo = 0; pol_hi = 18000; drop_inside = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // Directed: zero planar radius, negative x axis, extremes, axes.
        pending_points.push_back('{16'sd0, 16'sd0, 16'sd5});
        pending_points.push_back('{16'sd0, 16'sd0, 16'sd0});
        pending_points.push_back('{-16'sd100, 16'sd0, 16'sd0});
        pending_points.push_back('{16'sh8000, 16'sd0, 16'sh8000});
        pending_points.push_back('{16'sd100, 16'sd0, 16'sd0});
        pending_points.push_back('{16'sd0, 16'sd100, 16'sd1});
        pending_points.push_back('{16'sd0, -16'sd100, -16'sd1});
        pending_points.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff});
        pending_points.push_back('{16'sh8000, 16'sh8000, 16'sh8000});
        pending_points.push_back('{16'sh7fff, 16'sh8000, 16'sd0});
        pending_points.push_back('{-16'sd1, -16'sd1, 16'sh7fff});
        pending_points.push_back('{16'sd1, 16'sd0, 16'sh8000});
        drain();
        set_window(-9000, 9000, 3000, 15000, 1'b0);
        push_random(250);
        drain();
        write_reg(CFG_BOGUS, 16'h1234);
        set_window(-9000, 9000, 3000, 15000, 1'b1);
        push_random(250);
        drain();
        // Inverted and out-of-range bounds, compared as given.
        set_window(18000, -18000, 18000, 0, 1'b0);
        push_random(100);
        drain();
        set_window(-32768, 32767, 32767, 0, 1'b1);
        push_random(150);
        drain();
        set_window(0, 18000, 0, 9000, 1'b0);
        calm = 1'b1;
        push_random(300);
        drain();
        calm = 1'b0;
        set_window(-18000, 0, 9000, 18000, 1'b1);
        push_random(300);
        hold_sender = 1'b1;
        while (kept_points.size() > 0 || (i_in_valid && o_in_stall)) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
        hold_sender = 1'b0;
        drain();
        set_window(-18000, 18000, 0, 18000, 1'b0);
        push_random(600);
        drain();
        if (mismatches == 0 && kept_points.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
